// File: rtl/n2a_pkg.sv
// Shared types, constants and helpers for the number to ASCII formatter.
`default_nettype none

package n2a_pkg;

    localparam int DEFAULT_VALUE_WIDTH = 64;
    localparam int MAX_DIGITS = 20;
    localparam int MAX_PAD = 16;
    localparam int DEC_BASE = 10;
    localparam int CNT_W = 5;

    localparam logic [1:0] MODE_DEC  = 2'd0;
    localparam logic [1:0] MODE_HEX  = 2'd1;
    localparam logic [1:0] MODE_PAD  = 2'd2;
    localparam logic [1:0] MODE_NONE = 2'd3;

    localparam logic [6:0] ASCII_ZERO = 7'h30;
    localparam logic [6:0] ASCII_A    = 7'h41;

    typedef struct packed {
        logic [63:0] value;
        logic [1:0]  mode;
        logic [4:0]  pad_digits;
    } t_in_word;

    typedef struct packed {
        logic [6:0] ascii_char;
        logic       last;
    } t_out_word;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIGIT,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic start;
        logic load;
        logic hex;
    } t_unit_cmd;

    typedef struct packed {
        logic       done;
        logic [3:0] digit;
        logic       zero;
    } t_unit_sts;

    function automatic logic [6:0] digit_to_ascii(input logic [3:0] d);
        logic [6:0] c;
        if (d < 4'(DEC_BASE)) begin
            c = ASCII_ZERO + {3'b000, d};
        end else begin
            c = ASCII_A + {3'b000, d} - 7'(DEC_BASE);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// File: rtl/number_to_ascii_formatter.sv
// Top level of the number to ASCII formatter: sequencer, digit store and output word.
`default_nettype none

// Accepts one number word and prints it as ASCII, most significant digit first,
// one character per output word, last set on the final one. Mode 0 is decimal,
// mode 1 uppercase hex, both without leading zeros; mode 2 is hex padded with
// zeros to max(pad_digits, natural count), pad above 16 counting as 16. Mode 3
// is accepted and prints nothing. Only the low VALUE_WIDTH bits of value count.
// A number is accepted, then each digit is found: in hex by peeling one nibble,
// in decimal by the shared divide-by-ten unit in S = ceil(VALUE_WIDTH/4) steps,
// retiring four quotient bits a cycle; then one character goes out per cycle
// while the output side does not stall. In modes 0 to 2 the input stalls from
// acceptance until the last character is loaded into the output word register,
// so the next number starts while that character waits.
module number_to_ascii_formatter #(
    parameter int VALUE_WIDTH = n2a_pkg::DEFAULT_VALUE_WIDTH
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_in_valid,
    output logic                   o_in_stall,
    input  wire n2a_pkg::t_in_word i_in_word,
    output logic                   o_out_valid,
    input  wire                    i_out_stall,
    output n2a_pkg::t_out_word     o_out_word
);
    import n2a_pkg::*;

    t_state          r_state, n_state;
    t_unit_cmd       cmd;
    t_unit_sts       sts;

    logic            r_hex;
    logic [CNT_W-1:0] r_padc;      // clamped pad, zero outside padded mode
    logic [CNT_W-1:0] r_nat;       // natural digits held so far
    logic [CNT_W-1:0] r_idx;       // next digit to print, counts down
    logic [3:0]      r_store [MAX_DIGITS];
    logic            r_out_valid;
    t_out_word       r_out;

    logic            accept;
    logic            go;
    logic [CNT_W-1:0] nat_inc;
    logic [CNT_W-1:0] limit;
    logic            finish;
    logic [CNT_W-1:0] total;
    logic [CNT_W-1:0] pad_clamp;
    logic            emit_go;

    n2a_digit_unit #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_digit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_load_value(i_in_word.value[VALUE_WIDTH-1:0]),
        .o_sts       (sts)
    );

    assign o_in_stall = (r_state != ST_IDLE);
    assign accept     = i_in_valid && !o_in_stall;
    assign go         = accept && (i_in_word.mode != MODE_NONE);

    assign nat_inc   = r_nat + CNT_W'(1);
    assign limit     = r_hex ? CNT_W'(MAX_PAD) : CNT_W'(MAX_DIGITS);
    assign finish    = sts.zero || (nat_inc == limit);
    assign total     = (r_padc > nat_inc) ? r_padc : nat_inc;
    assign pad_clamp = (i_in_word.pad_digits > CNT_W'(MAX_PAD)) ?
                       CNT_W'(MAX_PAD) : i_in_word.pad_digits;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (go) n_state = ST_DIGIT;
            ST_DIGIT: if (sts.done && finish) n_state = ST_EMIT;
            ST_EMIT:  if (emit_go && r_idx == '0) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        cmd     = '0;
        emit_go = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                cmd.start = go;
                cmd.load  = 1'b1;
                cmd.hex   = (i_in_word.mode != MODE_DEC);
            end
            ST_DIGIT: begin
                cmd.start = sts.done && !finish;
                cmd.hex   = r_hex;
            end
            ST_EMIT: begin
                emit_go = !r_out_valid || !i_out_stall;
            end
            default: begin
                cmd     = '0;
                emit_go = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_nat       <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_IDLE && go) begin
                r_hex  <= (i_in_word.mode != MODE_DEC);
                r_padc <= (i_in_word.mode == MODE_PAD) ? pad_clamp : '0;
                r_nat  <= '0;
            end
            if (r_state == ST_DIGIT && sts.done) begin
                r_nat <= nat_inc;
                if (finish) begin
                    r_idx <= total - CNT_W'(1);
                end
            end
            if (emit_go) begin
                r_out_valid <= 1'b1;
                r_idx       <= r_idx - CNT_W'(1);
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Digit store and output word payload
    always_ff @(posedge i_clk) begin
        if (r_state == ST_DIGIT && sts.done) begin
            r_store[r_nat] <= sts.digit;
        end
        if (emit_go) begin
            // Pad positions beyond the natural digits print as zero.
            r_out.ascii_char <= digit_to_ascii((r_idx < r_nat) ? r_store[r_idx] : 4'd0);
            r_out.last       <= (r_idx == '0);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    a_emit_has_digits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |-> (r_nat != '0))
        else $error("printing with no digits held");
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |-> (r_idx < CNT_W'(MAX_DIGITS)))
        else $error("print index beyond digit store");
    a_nat_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nat <= CNT_W'(MAX_DIGITS))
        else $error("digit count overflow");

endmodule

`default_nettype wire

// File: rtl/n2a_digit_unit.sv
// Shared digit extractor: divide by ten four bits a cycle, or peel one hex nibble.
`default_nettype none

module n2a_digit_unit #(
    parameter int VALUE_WIDTH = n2a_pkg::DEFAULT_VALUE_WIDTH
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire n2a_pkg::t_unit_cmd i_cmd,
    input  wire [VALUE_WIDTH-1:0]   i_load_value,
    output n2a_pkg::t_unit_sts      o_sts
);
    import n2a_pkg::*;

    localparam int WORK_W = ((VALUE_WIDTH + 3) / 4) * 4;
    localparam int STEPS  = WORK_W / 4;
    localparam int STEP_W = (STEPS > 1) ? $clog2(STEPS) : 1;

    logic [WORK_W-1:0] r_work, n_work;
    logic [3:0]        r_rem, n_rem;
    logic [STEP_W-1:0] r_cnt;
    logic              r_run;
    logic              r_done;

    logic [WORK_W-1:0] op;
    logic [3:0]        chunk;
    logic [3:0]        qbits;

    assign op = i_cmd.load ? WORK_W'(i_load_value) : r_work;
    assign chunk = r_work[WORK_W-1 -: 4];

    // Four restoring steps on the running remainder per cycle.
    always_comb begin
        logic [4:0] t;
        logic [3:0] rem;
        rem = r_rem;
        qbits = 4'b0000;
        for (int b = 3; b >= 0; b--) begin
            t = {rem, chunk[b]};
            if (t >= 5'(DEC_BASE)) begin
                qbits[b] = 1'b1;
                rem = 4'(t - 5'(DEC_BASE));
            end else begin
                rem = t[3:0];
            end
        end
        n_rem = rem;
        n_work = {r_work[WORK_W-5:0], qbits};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.start) begin
                if (i_cmd.hex) begin
                    r_rem  <= op[3:0];
                    r_work <= op >> 4;
                    r_done <= 1'b1;
                end else begin
                    r_work <= op;
                    r_rem  <= 4'd0;
                    r_run  <= 1'b1;
                    r_cnt  <= '0;
                end
            end else if (r_run) begin
                r_work <= n_work;
                r_rem  <= n_rem;
                r_cnt  <= r_cnt + STEP_W'(1);
                if (r_cnt == STEP_W'(STEPS - 1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_sts.done  = r_done;
    assign o_sts.digit = r_rem;
    assign o_sts.zero  = (r_work == '0);

    a_no_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.start |-> !r_run)
        else $error("digit unit started while dividing");
    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_run |-> (r_rem < 4'(DEC_BASE)))
        else $error("decimal remainder out of range");
    a_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_run && r_cnt == STEP_W'(STEPS - 1)) |=> (r_done && !r_run))
        else $error("division did not finish on its last step");

endmodule

`default_nettype wire

// File: verif/testbench.sv
// Self-checking testbench for the number to ASCII formatter.
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import n2a_pkg::*;

    localparam int VALUE_WIDTH = DEFAULT_VALUE_WIDTH;
    localparam logic [63:0] VALUE_MASK =
        (VALUE_WIDTH >= 64) ? {64{1'b1}} : ((64'd1 << VALUE_WIDTH) - 64'd1);
    // Drain time after the last owed word, with a margin over a 20-digit decimal number.
    localparam int DRAIN_CYCLES = 500;
    // Hard limit on cycles for the whole run of directed and random numbers.
    localparam int CYCLE_LIMIT = 600000;
    localparam int NUM_MODES = 4;

    // DUT connections; the driven inputs are known from time zero.
    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_stall;
    t_in_word  in_word = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_word out_word;

    // Characters still owed by the DUT, oldest first.
    t_out_word expected_chars[$];

    int error_count = 0;
    int chars_checked = 0;
    int cycle_count = 0;
    int numbers_per_mode[NUM_MODES];
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    number_to_ascii_formatter #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_word  (in_word),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_word (out_word)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // Hard stop in case the DUT hangs or stalls forever.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("%0t: run hit the cycle limit of %0d", $time, CYCLE_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic logic [6:0] digit_char(input logic [3:0] d);
        if (d < 4'(DEC_BASE)) begin
            return ASCII_ZERO + 7'(d);
        end
        return ASCII_A + 7'(d) - 7'(DEC_BASE);
    endfunction

    // Splits the number into digits (least significant first) exactly as the
    // mode asks, then queues them most significant first with last on the end.
    function automatic void predict_chars(input t_in_word w);
        logic [63:0] rest;
        logic [3:0]  digits [MAX_DIGITS];
        int          n;
        int          pad;
        t_out_word   c;
        rest = w.value & VALUE_MASK;
        n = 0;
        case (w.mode)
            MODE_DEC: begin
                do begin
                    digits[n] = 4'(rest % 64'(DEC_BASE));
                    rest = rest / 64'(DEC_BASE);
                    n++;
                end while (rest != 0 && n < MAX_DIGITS);
            end
            MODE_HEX, MODE_PAD: begin
                do begin
                    digits[n] = rest[3:0];
                    rest = rest >> 4;
                    n++;
                end while (rest != 0 && n < MAX_PAD);
                if (w.mode == MODE_PAD) begin
                    // Pad above 16 clamps; a pad below the natural count is moot.
                    pad = (int'(w.pad_digits) > MAX_PAD) ? MAX_PAD : int'(w.pad_digits);
                    while (n < pad) begin
                        digits[n] = 4'd0;
                        n++;
                    end
                end
            end
            default: begin
                // unused mode: no characters
            end
        endcase
        for (int k = n - 1; k >= 0; k--) begin
            c.ascii_char = digit_char(digits[k]);
            c.last = (k == 0);
            expected_chars.push_back(c);
        end
    endfunction

    // Drives one number word, holds it until accepted, then maybe idles.
    // valid is only lowered when an idle cycle follows, never toggled in a step.
    task automatic send_number(input t_in_word w);
        in_valid <= 1'b1;
        in_word <= w;
        do @(posedge clk); while (in_stall);
        predict_chars(w);
        numbers_per_mode[w.mode]++;
        if ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            in_word <= {$urandom, $urandom, 7'($urandom)};
            do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
        end
    endtask

    function automatic t_in_word make_word(input logic [63:0] v, input logic [1:0] m,
                                           input logic [4:0] p);
        t_in_word w;
        w.value = v;
        w.mode = m;
        w.pad_digits = p;
        return w;
    endfunction

    // Receiver: random stall, and each accepted word checked against the queue.
    always @(posedge clk) begin : check_output
        t_out_word want;
        out_stall <= ($urandom_range(99) < recv_stall_pct);
        if (rst_n && out_valid && !out_stall) begin
            chars_checked++;
            if (expected_chars.size() == 0) begin
                error_count++;
                $display("%0t: unexpected word char=%h last=%b", $time,
                         out_word.ascii_char, out_word.last);
            end else begin
                want = expected_chars.pop_front();
                if (out_word.ascii_char !== want.ascii_char) begin
                    error_count++;
                    $display("%0t: ascii_char expected %h actual %h", $time,
                             want.ascii_char, out_word.ascii_char);
                end
                if (out_word.last !== want.last) begin
                    error_count++;
                    $display("%0t: last expected %b actual %b", $time,
                             want.last, out_word.last);
                end
            end
        end
    end

    // Decimal: zero, single digits, the ten boundary and the full 20 digits.
    task automatic test_decimal();
        send_number(make_word(64'd0, MODE_DEC, 5'd0));
        send_number(make_word(64'd9, MODE_DEC, 5'd31));
        send_number(make_word(64'd10, MODE_DEC, 5'd0));
        send_number(make_word(64'd9999999999999999999, MODE_DEC, 5'd7));
        send_number(make_word(64'd10000000000000000000, MODE_DEC, 5'd0));
        send_number(make_word({64{1'b1}}, MODE_DEC, 5'd16));
    endtask

    // Plain hex: zero, one and two digits, mixed letters and all ones.
    task automatic test_hex();
        send_number(make_word(64'd0, MODE_HEX, 5'd16));
        send_number(make_word(64'hF, MODE_HEX, 5'd0));
        send_number(make_word(64'h10, MODE_HEX, 5'd31));
        send_number(make_word(64'hABCDEF, MODE_HEX, 5'd0));
        send_number(make_word({64{1'b1}}, MODE_HEX, 5'd0));
        send_number(make_word(64'h8000_0000_0000_0000, MODE_HEX, 5'd0));
    endtask

    // Padded hex: pad of zero, too small, larger, clamped above 16, on zero.
    task automatic test_padded();
        send_number(make_word(64'd0, MODE_PAD, 5'd0));
        send_number(make_word(64'd0, MODE_PAD, 5'd5));
        send_number(make_word(64'd0, MODE_PAD, 5'd16));
        send_number(make_word(64'd1, MODE_PAD, 5'd17));
        send_number(make_word(64'd1, MODE_PAD, 5'd31));
        send_number(make_word(64'h1234, MODE_PAD, 5'd2));
        send_number(make_word(64'h1234, MODE_PAD, 5'd8));
        send_number(make_word({64{1'b1}}, MODE_PAD, 5'd3));
        send_number(make_word(64'h0123_4567_89AB_CDEF, MODE_PAD, 5'd16));
    endtask

    // Mode 3 must be taken and print nothing, also between real numbers.
    task automatic test_unused_mode();
        send_number(make_word({64{1'b1}}, MODE_NONE, 5'd31));
        send_number(make_word(64'd0, MODE_NONE, 5'd0));
        send_number(make_word(64'd42, MODE_DEC, 5'd0));
    endtask

    // Random numbers of spread length in all modes; unused mode is noise only
    // and does not count toward the total.
    task automatic test_random_traffic(input int count, input int send_pct,
                                       input int recv_pct);
        t_in_word w;
        int       done;
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
        done = 0;
        while (done < count) begin
            w.value = {$urandom, $urandom} >> $urandom_range(63, 0);
            if ($urandom_range(9) == 0) begin
                w.value = {$urandom, $urandom};
            end
            w.mode = ($urandom_range(99) < 6) ? MODE_NONE : 2'($urandom_range(2));
            w.pad_digits = ($urandom_range(3) == 0) ? 5'($urandom_range(31))
                                                     : 5'($urandom_range(MAX_PAD));
            send_number(w);
            if (w.mode != MODE_NONE) begin
                done++;
            end
        end
    endtask

    initial begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // directed cases under sparse sender idling and heavy output stall
        send_idle_pct = 9;
        recv_stall_pct = 77;
        test_decimal();
        test_hex();
        test_padded();
        test_unused_mode();

        test_random_traffic(60, 9, 77);
        test_random_traffic(60, 77, 9);
        test_random_traffic(60, 0, 0);
        in_valid <= 1'b0;

        // wait for every owed word, then a full decimal latency for strays
        while (expected_chars.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Numbers sent: %0d decimal, %0d hex, %0d padded hex, %0d unused mode",
                 numbers_per_mode[MODE_DEC], numbers_per_mode[MODE_HEX],
                 numbers_per_mode[MODE_PAD], numbers_per_mode[MODE_NONE]);
        $display("Characters checked: %0d in %0d cycles, %0d mismatches",
                 chars_checked, cycle_count, error_count);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

`default_nettype wire
